>>> design/rhb_pkg.sv
`default_nettype none
package rhb_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [7:0]  EMPTY_ID    = 8'd24;
  localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_REPLACE = 2'd1;
  localparam logic [1:0] OP_POP     = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  // per-step command for the head of the ring
  typedef struct packed {
    logic clear;
    logic write;
    logic replace;
  } head_cmd_t;

  // work latched at accept, applied while the ring turns once
  typedef struct packed {
    logic              clr_en;
    logic [SLOT_W-1:0] clr_slot;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic              replace;
    logic              cap_id_en;
    logic              cap_value_en;
    logic [SLOT_W-1:0] cap_slot;
    logic [7:0]        id;
    logic [31:0]       value;
    logic [31:0]       old_value;
  } job_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

endpackage
`default_nettype wire

>>> design/rhb_if.sv
`default_nettype none
interface rhb_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [7:0]         id;
  logic signed [31:0] value;
  logic signed [31:0] old_value;
  logic [3:0]         index;

  modport source (output valid, op, id, value, old_value, index, input ready);
  modport sink   (input valid, op, id, value, old_value, index, output ready);
endinterface

interface rhb_rsp_if;
  logic               valid;
  logic               ready;
  logic [7:0]         out_id;
  logic signed [31:0] out_value;
  logic               found;
  logic               was_empty;
  logic               index_error;

  modport source (output valid, out_id, out_value, found, was_empty, index_error,
                  input ready);
  modport sink   (input valid, out_id, out_value, found, was_empty, index_error,
                  output ready);
endinterface
`default_nettype wire

>>> design/ring_history_buffer_top.sv
`default_nettype none
// channel | dir | payload
// req     | in  | op, id, value, old_value, index
// rsp     | out | out_id, out_value, found, was_empty, index_error
//
// Every request turns the ring of SLOTS cells once after its accept cycle;
// no new request is taken until that turn is over.
// The head cell sees slot k at step k and applies clear, write or replace.
// rst clears pointers and sets every cell to the empty pair at once.
// A new request is taken while a result waits; a stalled rsp holds the
// ring idle at the end of its turn until the result register frees.
module ring_history_buffer_top
  import rhb_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  rhb_req_if.sink   req,
  rhb_rsp_if.source rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;
  localparam int SUM_W = SLOT_W + 5;

  logic [1:0]        state;
  logic [SLOT_W-1:0] step;
  logic [SLOT_W-1:0] oldest;
  logic [SLOT_W-1:0] nxt;
  job_t              job;
  job_t              job_next;

  logic [7:0]  res_id,    res_id_next;
  logic [31:0] res_value, res_value_next;
  logic        res_found, res_found_next;
  logic        res_empty, res_empty_next;
  logic        res_err,   res_err_next;

  logic [7:0]  cell_id    [SLOTS];
  logic [31:0] cell_value [SLOTS];
  logic [7:0]  head_id;
  logic [31:0] head_value;
  logic        match;
  head_cmd_t   cmd;

  logic accept, last, out_free, load_out, shift;
  logic empty, full, idx_err;
  logic [SUM_W-1:0]  rd_sum;
  logic [SLOT_W-1:0] rd_slot;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign shift     = (state == ST_RUN);
  assign last      = (step == SLOT_W'(SLOTS - 1));
  assign out_free  = !rsp.valid || rsp.ready;
  assign load_out  = ((state == ST_RUN) && last && out_free) ||
                     ((state == ST_HOLD) && out_free);

  assign empty   = (nxt == oldest);
  assign full    = (slot_inc(nxt) == oldest);
  assign idx_err = (SUM_W'(req.index) >= SUM_W'(SLOTS - 1));
  assign rd_sum  = SUM_W'(nxt) + SUM_W'(SLOTS) - SUM_W'(req.index) - SUM_W'(1);
  assign rd_slot = (rd_sum >= SUM_W'(SLOTS)) ? SLOT_W'(rd_sum - SUM_W'(SLOTS))
                                             : SLOT_W'(rd_sum);

  always_comb begin
    job_next              = '0;
    job_next.id           = req.id;
    job_next.value        = req.value;
    job_next.old_value    = req.old_value;
    job_next.clr_slot     = oldest;
    job_next.wr_slot      = nxt;
    job_next.cap_slot     = oldest;
    unique case (req.op)
      OP_PUSH: begin
        job_next.clr_en = full;
        job_next.wr_en  = 1'b1;
      end
      OP_REPLACE: begin
        job_next.replace = 1'b1;
      end
      OP_POP: begin
        job_next.clr_en    = !empty;
        job_next.cap_id_en = !empty;
      end
      OP_READ: begin
        job_next.cap_id_en    = !idx_err;
        job_next.cap_value_en = !idx_err;
        job_next.cap_slot     = rd_slot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      step   <= '0;
      oldest <= '0;
      nxt    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
            step  <= '0;
            if (req.op == OP_PUSH) begin
              nxt <= slot_inc(nxt);
              if (full) begin
                oldest <= slot_inc(oldest);
              end
            end else if (req.op == OP_POP && !empty) begin
              oldest <= slot_inc(oldest);
            end
          end
        end
        ST_RUN: begin
          step <= last ? '0 : step + SLOT_W'(1);
          if (last) begin
            state <= out_free ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

  assign cmd.clear   = job.clr_en && (step == job.clr_slot);
  assign cmd.write   = job.wr_en && (step == job.wr_slot);
  assign cmd.replace = job.replace;

  rhb_head u_head (
    .cmd       (cmd),
    .cur_id    (cell_id[0]),
    .cur_value (cell_value[0]),
    .wr_id     (job.id),
    .wr_value  (job.value),
    .old_value (job.old_value),
    .new_id    (head_id),
    .new_value (head_value),
    .match     (match)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic [7:0]  d_id;
    logic [31:0] d_value;
    if (i == SLOTS - 1) begin : g_tail
      assign d_id    = head_id;
      assign d_value = head_value;
    end else begin : g_mid
      assign d_id    = cell_id[i+1];
      assign d_value = cell_value[i+1];
    end
    rhb_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .d_id    (d_id),
      .d_value (d_value),
      .q_id    (cell_id[i]),
      .q_value (cell_value[i])
    );
  end

  always_comb begin
    res_id_next    = res_id;
    res_value_next = res_value;
    res_found_next = res_found;
    res_empty_next = res_empty;
    res_err_next   = res_err;
    if (accept) begin
      res_id_next    = EMPTY_ID;
      res_value_next = EMPTY_VALUE;
      res_found_next = 1'b0;
      res_empty_next = (req.op == OP_POP) && empty;
      res_err_next   = (req.op == OP_READ) && idx_err;
    end else if (state == ST_RUN) begin
      if (job.cap_id_en && step == job.cap_slot) begin
        res_id_next = cell_id[0];
      end
      if (job.cap_value_en && step == job.cap_slot) begin
        res_value_next = cell_value[0];
      end
      if (match) begin
        res_found_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_id    <= res_id_next;
    res_value <= res_value_next;
    res_found <= res_found_next;
    res_empty <= res_empty_next;
    res_err   <= res_err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.out_id      <= res_id_next;
      rsp.out_value   <= res_value_next;
      rsp.found       <= res_found_next;
      rsp.was_empty   <= res_empty_next;
      rsp.index_error <= res_err_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_turn: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RUN) && (step == '0))
    else $error("request accept did not start a ring turn");

  a_turn_runs_through: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && !last |=> (state == ST_RUN))
    else $error("ring turn ended early");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (SUM_W'(oldest) < SUM_W'(SLOTS)) && (SUM_W'(nxt) < SUM_W'(SLOTS)))
    else $error("ring pointer out of range");

  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !load_out)
    else $error("result register overwritten while stalled");
`endif

endmodule
`default_nettype wire

>>> design/rhb_cell.sv
`default_nettype none
module rhb_cell
  import rhb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        shift,
  input  wire logic [7:0]  d_id,
  input  wire logic [31:0] d_value,
  output logic      [7:0]  q_id,
  output logic      [31:0] q_value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_id    <= EMPTY_ID;
      q_value <= EMPTY_VALUE;
    end else if (shift) begin
      q_id    <= d_id;
      q_value <= d_value;
    end
  end

endmodule
`default_nettype wire

>>> design/rhb_head.sv
`default_nettype none
module rhb_head
  import rhb_pkg::*;
(
  input  wire head_cmd_t   cmd,
  input  wire logic [7:0]  cur_id,
  input  wire logic [31:0] cur_value,
  input  wire logic [7:0]  wr_id,
  input  wire logic [31:0] wr_value,
  input  wire logic [31:0] old_value,
  output logic      [7:0]  new_id,
  output logic      [31:0] new_value,
  output logic             match
);

  assign match = cmd.replace && (cur_value == old_value);

  always_comb begin
    new_id    = cur_id;
    new_value = cur_value;
    if (cmd.write) begin
      new_id    = wr_id;
      new_value = wr_value;
    end else if (cmd.clear) begin
      new_id    = EMPTY_ID;
      new_value = EMPTY_VALUE;
    end else if (match) begin
      new_value = wr_value;
    end
  end

endmodule
`default_nettype wire
